// ----- hdl/dcfp_pkg.sv -----
// shared types, event codes and command code table for the drive command frame parser
`default_nettype none
package dcfp_pkg;

    localparam int unsigned TimeoutW = 20;
    localparam int unsigned EventW   = 4;
    localparam int unsigned NumCodes = 7;

    localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 20'd10000;

    localparam logic [7:0] START_DRIVE = 8'd35;
    localparam logic [7:0] START_CMD   = 8'd38;

    localparam logic [EventW-1:0] EV_DRIVE    = 4'd0;
    localparam logic [EventW-1:0] EV_START    = 4'd1;
    localparam logic [EventW-1:0] EV_STOP     = 4'd2;
    localparam logic [EventW-1:0] EV_STRAIGHT = 4'd3;
    localparam logic [EventW-1:0] EV_DBG_ON   = 4'd4;
    localparam logic [EventW-1:0] EV_DBG_OFF  = 4'd5;
    localparam logic [EventW-1:0] EV_DEACT    = 4'd6;
    localparam logic [EventW-1:0] EV_STOP_LNK = 4'd7;
    localparam logic [EventW-1:0] EV_TIMEOUT  = 4'd8;

    // three bytes per code, first byte in the low bits
    localparam logic [23:0] CODE_TABLE [NumCodes] = '{
        {8'd65,  8'd45, 8'd25},
        {8'd39,  8'd26, 8'd13},
        {8'd185, 8'd8,  8'd91},
        {8'd123, 8'd79, 8'd38},
        {8'd115, 8'd39, 8'd31},
        {8'd23,  8'd89, 8'd67},
        {8'd129, 8'd63, 8'd34}
    };

    typedef struct packed {
        logic              valid;
        logic [EventW-1:0] code;
        logic [7:0]        speed;
        logic [7:0]        steer;
    } dcfp_evt_t;

    // returns the matching event code, or EV_DRIVE when no code matches
    function automatic logic [EventW-1:0] code_lookup(input logic [23:0] frame);
        logic [EventW-1:0] hit;
        hit = EV_DRIVE;
        for (int i = NumCodes - 1; i >= 0; i--) begin
            if (CODE_TABLE[i] == frame) begin
                hit = EventW'(i + 1);
            end
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/dcfp_parser.sv -----
// frame parser: start byte hunt, payload capture, checksum and code match, flags
`default_nettype none
module dcfp_parser
    import dcfp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       byte_en,
    input  wire logic [7:0] rx_byte,
    output dcfp_evt_t       evt,
    output logic            debug_next,
    output logic            led_next
);

    localparam logic [1:0] KIND_HUNT  = 2'd0;
    localparam logic [1:0] KIND_DRIVE = 2'd1;
    localparam logic [1:0] KIND_CMD   = 2'd2;

    logic [1:0] kind_reg, kind_next;
    logic [1:0] taken_reg, taken_next;
    logic [7:0] p0_reg, p1_reg;
    logic       debug_reg, led_reg;
    logic [7:0] csum;
    logic [EventW-1:0] hit;

    assign csum = p0_reg + {p1_reg[6:0], 1'b0};
    assign hit  = code_lookup({rx_byte, p1_reg, p0_reg});

    always_comb begin
        kind_next  = kind_reg;
        taken_next = taken_reg;
        debug_next = debug_reg;
        led_next   = led_reg;
        evt        = '0;
        if (byte_en) begin
            case (kind_reg)
                KIND_DRIVE, KIND_CMD: begin
                    if (taken_reg < 2'd2) begin
                        taken_next = taken_reg + 2'd1;
                    end else begin
                        kind_next  = KIND_HUNT;
                        taken_next = 2'd0;
                        if (kind_reg == KIND_DRIVE) begin
                            if (csum == rx_byte) begin
                                evt.valid = 1'b1;
                                evt.code  = EV_DRIVE;
                                evt.speed = p0_reg;
                                evt.steer = p1_reg;
                            end
                        end else if (hit != EV_DRIVE) begin
                            evt.valid = 1'b1;
                            evt.code  = hit;
                            if (hit == EV_START) led_next = 1'b1;
                            if (hit == EV_DBG_ON) debug_next = 1'b1;
                            if (hit == EV_DBG_OFF) debug_next = 1'b0;
                        end
                    end
                end
                default: begin
                    taken_next = 2'd0;
                    if (rx_byte == START_DRIVE) begin
                        kind_next = KIND_DRIVE;
                    end else if (rx_byte == START_CMD) begin
                        kind_next = KIND_CMD;
                    end else begin
                        kind_next = KIND_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= KIND_HUNT;
            taken_reg <= 2'd0;
            debug_reg <= 1'b1;
            led_reg   <= 1'b0;
        end else begin
            kind_reg  <= kind_next;
            taken_reg <= taken_next;
            debug_reg <= debug_next;
            led_reg   <= led_next;
        end
    end

    // payload bytes need no reset
    always_ff @(posedge aclk) begin
        if (byte_en && (kind_reg == KIND_DRIVE || kind_reg == KIND_CMD)) begin
            if (taken_reg == 2'd0) p0_reg <= rx_byte;
            if (taken_reg == 2'd1) p1_reg <= rx_byte;
        end
    end

    a_hunt_no_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        kind_reg == KIND_HUNT |-> taken_reg == 2'd0)
        else $error("payload count nonzero while hunting");

    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        evt.valid |-> taken_reg == 2'd2 && byte_en)
        else $error("event outside the last payload byte");

endmodule
`default_nettype wire

// ----- hdl/dcfp_watchdog.sv -----
// one-shot link watchdog counting ticks since the last accepted frame
`default_nettype none
module dcfp_watchdog
    import dcfp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                tick,
    input  wire logic                arm,
    input  wire logic [TimeoutW-1:0] period,
    output logic                     fire
);

    logic                armed_reg, armed_next;
    logic [TimeoutW-1:0] left_reg, left_next;

    always_comb begin
        armed_next = armed_reg;
        left_next  = left_reg;
        fire       = 1'b0;
        if (arm) begin
            armed_next = 1'b1;
            left_next  = period;
        end else if (tick && armed_reg) begin
            if (left_reg <= TimeoutW'(1)) begin
                armed_next = 1'b0;
                left_next  = '0;
                fire       = 1'b1;
            end else begin
                left_next = left_reg - TimeoutW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            left_reg  <= '0;
        end else begin
            armed_reg <= armed_next;
            left_reg  <= left_next;
        end
    end

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !armed_reg |-> left_reg == '0)
        else $error("disarmed watchdog holds a count");

    a_fire_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> !armed_reg)
        else $error("watchdog still armed after timeout");

endmodule
`default_nettype wire

// ----- hdl/drive_command_frame_parser.sv -----
// top level: input handshake, parser, watchdog and registered result item
// a result item is registered and appears on the m_ side in the cycle after its input item is taken
// throughput: one input item per cycle; s_tready drops only while a result item is stalled
// the parser state and the watchdog counter are updated in the same cycle as the item
// reset (aresetn low, synchronous): hunting, debug on, led off, watchdog disarmed,
// timeout period 10000 ticks, no result item pending
`default_nettype none
module drive_command_frame_parser
    import dcfp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [TimeoutW-1:0] cfg_wr_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // rx_byte
    input  wire logic [0:0]          s_tuser,   // op
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [23:0]              m_tdata,   // speed, steer, debug_enabled, led_on, zero fill
    output logic [EventW-1:0]        m_tuser    // event_res
);

    logic [TimeoutW-1:0] period_reg;
    logic                m_valid_reg, m_valid_next;
    logic [EventW-1:0]   ev_reg;
    logic [7:0]          speed_reg, steer_reg;
    logic                dbg_reg, led_reg;
    logic                take, byte_en, tick_en, fire, debug_next, led_next;
    dcfp_evt_t           evt;

    assign s_tready = !m_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;
    assign byte_en  = take && !s_tuser[0];
    assign tick_en  = take && s_tuser[0];

    dcfp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_en    (byte_en),
        .rx_byte    (s_tdata),
        .evt        (evt),
        .debug_next (debug_next),
        .led_next   (led_next)
    );

    dcfp_watchdog u_watchdog (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (tick_en),
        .arm     (evt.valid),
        .period  (period_reg),
        .fire    (fire)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            period_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) m_valid_next = 1'b0;
        if (evt.valid || fire) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (evt.valid || fire) begin
            ev_reg    <= fire ? EV_TIMEOUT : evt.code;
            speed_reg <= fire ? 8'd0 : evt.speed;
            steer_reg <= fire ? 8'd0 : evt.steer;
            dbg_reg   <= debug_next;
            led_reg   <= led_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = ev_reg;
    assign m_tdata  = {6'd0, led_reg, dbg_reg, steer_reg, speed_reg};

    a_one_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !(evt.valid && fire))
        else $error("frame event and timeout in the same item");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (evt.valid || fire) |-> !m_valid_reg || m_tready)
        else $error("result item overwritten while stalled");

endmodule
`default_nettype wire
